// ----- rtl/kts_pkg.sv -----
// Shared widths, register indexes and control bundles of the trajectory smoother.
// Used by every module under rtl/; depends on nothing.
package kts_pkg;

  localparam int STEP_W   = 28;  // input step, signed
  localparam int FIX_W    = 32;  // corrected motion, signed
  localparam int Q_W      = 24;  // process noise
  localparam int R_W      = 26;  // measurement noise
  localparam int LIM_W    = 31;  // warp limits
  localparam int VAR_FRAC = 24;  // fraction bits of variances and gain
  localparam int VAR_W    = 27;  // error variance
  localparam int PP_W     = 28;  // predicted variance
  localparam int DEN_W    = 29;  // gain denominator
  localparam int GAIN_W   = 25;  // gain, at most 1.0
  localparam int CHUNK_W  = 24;  // magnitude digit per multiply step
  localparam int CLAMP_SH = 40;  // difference limited to +-2^40
  localparam int DIFF_W   = 42;  // clamped difference, signed

  localparam logic [GAIN_W-1:0] VAR_ONE = GAIN_W'(1) << VAR_FRAC;

  localparam int CFG_AW = 4;
  localparam logic [1:0] REG_NOISE_Q = 2'd0;
  localparam logic [1:0] REG_NOISE_R = 2'd1;
  localparam logic [1:0] REG_LIMIT_X = 2'd2;
  localparam logic [1:0] REG_LIMIT_Y = 2'd3;

  // per-axis lane controls: strobes for the sequencer steps, plus the first and last flags
  typedef struct packed {
    logic load;   // add step to trajectory
    logic first;  // first frame: zero the estimate
    logic prep;   // form |sum - est|
    logic mac;    // one multiply-accumulate digit
    logic last;   // lowest digit
    logic upd;    // commit new estimate
    logic diff;   // form clamped est - sum
    logic fix;    // form saturated corrected step
  } kts_lane_ctl_t;

  typedef struct packed {
    logic start;  // compute gain and next variance
    logic first;  // first frame: variance back to 1.0
  } kts_gain_ctl_t;

endpackage

// ----- rtl/kts_gain.sv -----
// Shared gain unit: restoring divider for K = Pp/(Pp+R) and the variance update.
// Holds the error variance. Depends on kts_pkg.
module kts_gain (
  input  logic                       clk,
  input  logic                       rst_n,
  input  kts_pkg::kts_gain_ctl_t     ctl,
  input  logic [kts_pkg::Q_W-1:0]    noise_q,
  input  logic [kts_pkg::R_W-1:0]    noise_r,
  output logic [kts_pkg::GAIN_W-1:0] gain,
  output logic                       done
);

  localparam int CNT_W = $clog2(kts_pkg::GAIN_W);
  localparam int PRD_W = kts_pkg::GAIN_W + kts_pkg::PP_W;

  localparam logic [1:0] G_IDLE = 2'd0;
  localparam logic [1:0] G_DIV  = 2'd1;
  localparam logic [1:0] G_MUL  = 2'd2;
  localparam logic [1:0] G_VAR  = 2'd3;

  logic [1:0]                   gst_r, gst_nxt;
  logic [CNT_W-1:0]             cnt_r;
  logic [kts_pkg::PP_W-1:0]     pp_r, pp_nxt;
  logic [kts_pkg::DEN_W-1:0]    den_r, rem_r;
  logic [kts_pkg::GAIN_W-1:0]   quo_r, gain_r, kc;
  logic [PRD_W-1:0]             prod_r;
  logic [kts_pkg::VAR_W-1:0]    var_r;
  logic [kts_pkg::DEN_W:0]      trial;
  logic                         ge;

  assign pp_nxt = kts_pkg::PP_W'(var_r) + kts_pkg::PP_W'(noise_q);
  assign trial  = (cnt_r == CNT_W'(kts_pkg::GAIN_W - 1)) ? {1'b0, rem_r} : {rem_r, 1'b0};
  assign ge     = trial >= {1'b0, den_r};
  assign kc     = (quo_r > kts_pkg::VAR_ONE) ? kts_pkg::VAR_ONE : quo_r;

  always_comb begin
    gst_nxt = gst_r;
    unique case (gst_r)
      G_IDLE: if (ctl.start) gst_nxt = G_DIV;
      G_DIV:  if (cnt_r == '0) gst_nxt = G_MUL;
      G_MUL:  gst_nxt = G_VAR;
      G_VAR:  gst_nxt = G_IDLE;
      default: gst_nxt = G_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gst_r <= G_IDLE;
      var_r <= kts_pkg::VAR_W'(kts_pkg::VAR_ONE);
    end else begin
      gst_r <= gst_nxt;
      if (ctl.first) begin
        var_r <= kts_pkg::VAR_W'(kts_pkg::VAR_ONE);
      end else if (gst_r == G_VAR) begin
        var_r <= prod_r[kts_pkg::VAR_FRAC +: kts_pkg::VAR_W];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (gst_r == G_IDLE && ctl.start) begin
      pp_r  <= pp_nxt;
      den_r <= kts_pkg::DEN_W'(pp_nxt) + kts_pkg::DEN_W'(noise_r);
      rem_r <= kts_pkg::DEN_W'(pp_nxt);
      quo_r <= '0;
      cnt_r <= CNT_W'(kts_pkg::GAIN_W - 1);
    end else if (gst_r == G_DIV) begin
      // zero denominator sets every bit; the clamp turns that into 1.0
      rem_r <= ge ? kts_pkg::DEN_W'(trial - {1'b0, den_r}) : kts_pkg::DEN_W'(trial);
      quo_r <= {quo_r[kts_pkg::GAIN_W-2:0], ge};
      cnt_r <= cnt_r - CNT_W'(1);
    end else if (gst_r == G_MUL) begin
      gain_r <= kc;
      prod_r <= PRD_W'(kts_pkg::VAR_ONE - kc) * PRD_W'(pp_r);
    end
  end

  assign gain = gain_r;
  assign done = (gst_r == G_VAR);

endmodule

// ----- rtl/kts_lane.sv -----
// One axis of the smoother: trajectory sum, digit-serial gain multiply, estimate,
// clamped difference and saturated correction. Depends on kts_pkg.
module kts_lane #(
  parameter int ACC_WIDTH = 48
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  kts_pkg::kts_lane_ctl_t            ctl,
  input  logic signed [kts_pkg::STEP_W-1:0] step,
  input  logic [kts_pkg::GAIN_W-1:0]        gain,
  output logic signed [kts_pkg::FIX_W-1:0]  fix,
  output logic signed [kts_pkg::DIFF_W-1:0] diff
);

  localparam int MAG_W  = ACC_WIDTH + 1;
  localparam int NCHUNK = (MAG_W + kts_pkg::CHUNK_W - 1) / kts_pkg::CHUNK_W;
  localparam int PAD_W  = NCHUNK * kts_pkg::CHUNK_W;
  localparam int PROD_W = kts_pkg::CHUNK_W + kts_pkg::GAIN_W;
  localparam int EXT_W  = (MAG_W > kts_pkg::DIFF_W) ? MAG_W : kts_pkg::DIFF_W;
  localparam int SUM_W  = kts_pkg::DIFF_W + 1;

  localparam logic signed [ACC_WIDTH-1:0] ACC_MAX = {1'b0, {(ACC_WIDTH-1){1'b1}}};
  localparam logic signed [ACC_WIDTH-1:0] ACC_MIN = {1'b1, {(ACC_WIDTH-1){1'b0}}};
  localparam logic signed [EXT_W-1:0] DCLAMP = EXT_W'(1) << kts_pkg::CLAMP_SH;
  localparam logic signed [SUM_W-1:0] FIX_HI =
    (SUM_W'(1) << (kts_pkg::FIX_W - 1)) - SUM_W'(1);
  localparam logic signed [SUM_W-1:0] FIX_LO = -(SUM_W'(1) << (kts_pkg::FIX_W - 1));

  logic signed [ACC_WIDTH-1:0]      sum_r, est_r, sum_nxt;
  logic signed [kts_pkg::STEP_W-1:0] step_r;
  logic [PAD_W-1:0]                 mag_r;
  logic                             dir_r;
  logic [MAG_W-1:0]                 acc_r;
  logic signed [kts_pkg::DIFF_W-1:0] diff_r;
  logic signed [kts_pkg::FIX_W-1:0]  fix_r;

  logic signed [MAG_W-1:0]          sum_wide, dz;
  logic [MAG_W-1:0]                 mag;
  logic [PROD_W-1:0]                prod;
  logic signed [EXT_W-1:0]          d;
  logic signed [SUM_W-1:0]          f;

  assign sum_wide = {sum_r[ACC_WIDTH-1], sum_r}
                  + {{(MAG_W-kts_pkg::STEP_W){step[kts_pkg::STEP_W-1]}}, step};
  assign sum_nxt  = (sum_wide[MAG_W-1] != sum_wide[MAG_W-2])
                  ? (sum_wide[MAG_W-1] ? ACC_MIN : ACC_MAX)
                  : sum_wide[ACC_WIDTH-1:0];

  assign dz   = {sum_r[ACC_WIDTH-1], sum_r} - {est_r[ACC_WIDTH-1], est_r};
  assign mag  = dz[MAG_W-1] ? MAG_W'(-dz) : MAG_W'(dz);
  assign prod = PROD_W'(mag_r[PAD_W-1 -: kts_pkg::CHUNK_W]) * PROD_W'(gain);

  assign d = {{(EXT_W-ACC_WIDTH){est_r[ACC_WIDTH-1]}}, est_r}
           - {{(EXT_W-ACC_WIDTH){sum_r[ACC_WIDTH-1]}}, sum_r};
  assign f = {{(SUM_W-kts_pkg::STEP_W){step_r[kts_pkg::STEP_W-1]}}, step_r}
           + {diff_r[kts_pkg::DIFF_W-1], diff_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r <= '0;
      est_r <= '0;
    end else begin
      if (ctl.load) begin
        sum_r <= sum_nxt;
      end
      if (ctl.load && ctl.first) begin
        est_r <= '0;
      end else if (ctl.upd) begin
        est_r <= dir_r ? est_r + ACC_WIDTH'(acc_r) : est_r - ACC_WIDTH'(acc_r);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      step_r <= step;
    end
    if (ctl.prep) begin
      mag_r <= PAD_W'(mag);
      dir_r <= !dz[MAG_W-1];
      acc_r <= '0;
    end else if (ctl.mac) begin
      // top digit first; the lowest digit keeps only its integer part
      mag_r <= mag_r << kts_pkg::CHUNK_W;
      if (ctl.last) begin
        acc_r <= acc_r + MAG_W'(prod >> kts_pkg::VAR_FRAC);
      end else begin
        acc_r <= (acc_r << kts_pkg::CHUNK_W) + MAG_W'(prod);
      end
    end
    if (ctl.diff) begin
      if (d > DCLAMP) begin
        diff_r <= kts_pkg::DIFF_W'(DCLAMP);
      end else if (d < -DCLAMP) begin
        diff_r <= kts_pkg::DIFF_W'(-DCLAMP);
      end else begin
        diff_r <= kts_pkg::DIFF_W'(d);
      end
    end
    if (ctl.fix) begin
      if (f > FIX_HI) begin
        fix_r <= kts_pkg::FIX_W'(FIX_HI);
      end else if (f < FIX_LO) begin
        fix_r <= kts_pkg::FIX_W'(FIX_LO);
      end else begin
        fix_r <= kts_pkg::FIX_W'(f);
      end
    end
  end

  assign fix  = fix_r;
  assign diff = diff_r;

endmodule

// ----- rtl/kts_merge.sv -----
// Merge stage: combines the three lanes into one result word, decides the warp
// flag and holds the word in the output register. Depends on kts_pkg.
module kts_merge (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              load,
  input  logic signed [kts_pkg::FIX_W-1:0]  fix_x,
  input  logic signed [kts_pkg::FIX_W-1:0]  fix_y,
  input  logic signed [kts_pkg::FIX_W-1:0]  fix_angle,
  input  logic signed [kts_pkg::DIFF_W-1:0] diff_x,
  input  logic signed [kts_pkg::DIFF_W-1:0] diff_y,
  input  logic [kts_pkg::LIM_W-1:0]         limit_x,
  input  logic [kts_pkg::LIM_W-1:0]         limit_y,
  output logic                              ready,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [3*kts_pkg::FIX_W-1:0]       out_tdata,
  output logic [0:0]                        out_tuser
);

  logic                          tvalid_r;
  logic [3*kts_pkg::FIX_W-1:0]   tdata_r;
  logic [0:0]                    tuser_r;
  logic signed [kts_pkg::DIFF_W-1:0] lim_x, lim_y;
  logic                          skip;

  assign lim_x = {{(kts_pkg::DIFF_W-kts_pkg::LIM_W){1'b0}}, limit_x};
  assign lim_y = {{(kts_pkg::DIFF_W-kts_pkg::LIM_W){1'b0}}, limit_y};
  // positive side only
  assign skip  = (diff_x > lim_x) || (diff_y > lim_y);
  assign ready = !tvalid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tvalid_r <= 1'b0;
    end else if (load) begin
      tvalid_r <= 1'b1;
    end else if (out_tready) begin
      tvalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      tdata_r <= {fix_angle, fix_y, fix_x};
      tuser_r <= !skip;
    end
  end

  assign out_tvalid = tvalid_r;
  assign out_tdata  = tdata_r;
  assign out_tuser  = tuser_r;

endmodule

// ----- rtl/kalman_trajectory_smoother.sv -----
// Scalar Kalman trajectory smoother: three axis lanes, shared gain unit, merge stage.
// Steps per frame: IDLE, PREP, then DIV while the gain unit runs its 25 divider steps,
// MAC with one multiply per 24-bit digit, UPD, DIFF, FIX, SEND; the first frame skips
// DIV, MAC and UPD. Words are taken only in IDLE, also while a result waits.
// Reset (rst_n low at a clock edge) clears sums and estimates, sets the variance to 1.0,
// restores register defaults and arms first-frame handling. Depends on kts_pkg.
module kalman_trajectory_smoother #(
  parameter int ACC_WIDTH = 48
) (
  input  logic                        clk,
  input  logic                        rst_n,
  // input words
  input  logic                        in_tvalid,
  output logic                        in_tready,
  input  logic [87:0]                 in_tdata,   // step_x, step_y, step_angle, 4 pad bits
  // result words
  output logic                        out_tvalid,
  input  logic                        out_tready,
  output logic [95:0]                 out_tdata,  // fix_x, fix_y, fix_angle
  output logic [0:0]                  out_tuser,  // apply_warp
  // configuration
  input  logic                        cfg_psel,
  input  logic                        cfg_penable,
  input  logic                        cfg_pwrite,
  input  logic [kts_pkg::CFG_AW-1:0]  cfg_paddr,
  input  logic [31:0]                 cfg_pwdata,
  output logic [31:0]                 cfg_prdata,
  output logic                        cfg_pready
);

  localparam int MAG_W  = ACC_WIDTH + 1;
  localparam int NCHUNK = (MAG_W + kts_pkg::CHUNK_W - 1) / kts_pkg::CHUNK_W;
  localparam int MC_W   = (NCHUNK > 1) ? $clog2(NCHUNK) : 1;

  localparam logic signed [kts_pkg::DIFF_W-1:0] DIFF_MAX =
    kts_pkg::DIFF_W'(1) << kts_pkg::CLAMP_SH;

  // sequencer steps
  localparam logic [2:0] S_IDLE = 3'd0;  // wait for an input word
  localparam logic [2:0] S_PREP = 3'd1;  // lanes form |sum - est|, gain starts except on the first frame
  localparam logic [2:0] S_DIV  = 3'd2;  // wait for gain and variance
  localparam logic [2:0] S_MAC  = 3'd3;  // digit-serial gain multiply
  localparam logic [2:0] S_UPD  = 3'd4;  // commit estimates
  localparam logic [2:0] S_DIFF = 3'd5;  // clamped differences
  localparam logic [2:0] S_FIX  = 3'd6;  // saturated corrections
  localparam logic [2:0] S_SEND = 3'd7;  // hand result to merge stage

  logic [2:0]               state_r, state_nxt;
  logic                     first_r, cur_first_r;
  logic [MC_W-1:0]          mac_cnt_r;
  logic [kts_pkg::Q_W-1:0]   noise_q_r;
  logic [kts_pkg::R_W-1:0]   noise_r_r;
  logic [kts_pkg::LIM_W-1:0] limit_x_r, limit_y_r;

  logic                     in_accept, cfg_wr, mrg_ready, mrg_load, g_done;
  logic [kts_pkg::GAIN_W-1:0] gain;
  kts_pkg::kts_lane_ctl_t   lctl;
  kts_pkg::kts_gain_ctl_t   gctl;

  logic signed [kts_pkg::FIX_W-1:0]  fix_x, fix_y, fix_a;
  logic signed [kts_pkg::DIFF_W-1:0] diff_x, diff_y, diff_a;

  // ---------------------------------------------------------------- config port
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      noise_q_r <= kts_pkg::Q_W'(67109);
      noise_r_r <= kts_pkg::R_W'(4194304);
      limit_x_r <= kts_pkg::LIM_W'(31457280);
      limit_y_r <= kts_pkg::LIM_W'(17694720);
    end else if (cfg_wr) begin
      // low address bits are ignored; values are masked to register width
      unique case (cfg_paddr[3:2])
        kts_pkg::REG_NOISE_Q: noise_q_r <= cfg_pwdata[kts_pkg::Q_W-1:0];
        kts_pkg::REG_NOISE_R: noise_r_r <= cfg_pwdata[kts_pkg::R_W-1:0];
        kts_pkg::REG_LIMIT_X: limit_x_r <= cfg_pwdata[kts_pkg::LIM_W-1:0];
        kts_pkg::REG_LIMIT_Y: limit_y_r <= cfg_pwdata[kts_pkg::LIM_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_paddr[3:2])
      kts_pkg::REG_NOISE_Q: cfg_prdata = 32'(noise_q_r);
      kts_pkg::REG_NOISE_R: cfg_prdata = 32'(noise_r_r);
      kts_pkg::REG_LIMIT_X: cfg_prdata = 32'(limit_x_r);
      kts_pkg::REG_LIMIT_Y: cfg_prdata = 32'(limit_y_r);
      default:              cfg_prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------- sequencer
  // One frame at a time; the merge stage holds the finished word so the next
  // frame can be taken while the previous result is still waiting.
  assign in_tready = (state_r == S_IDLE);
  assign in_accept = in_tvalid && in_tready;
  assign mrg_load  = (state_r == S_SEND) && mrg_ready;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (in_accept) state_nxt = S_PREP;
      S_PREP: state_nxt = cur_first_r ? S_DIFF : S_DIV;
      S_DIV:  if (g_done) state_nxt = S_MAC;
      S_MAC:  if (mac_cnt_r == '0) state_nxt = S_UPD;
      S_UPD:  state_nxt = S_DIFF;
      S_DIFF: state_nxt = S_FIX;
      S_FIX:  state_nxt = S_SEND;
      S_SEND: if (mrg_ready) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      first_r     <= 1'b1;
      cur_first_r <= 1'b0;
      mac_cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      if (in_accept) begin
        first_r     <= 1'b0;
        cur_first_r <= first_r;
      end
      // walk digits from the top one down to the lowest
      if (state_r == S_DIV) begin
        mac_cnt_r <= MC_W'(NCHUNK - 1);
      end else if (state_r == S_MAC) begin
        mac_cnt_r <= mac_cnt_r - MC_W'(1);
      end
    end
  end

  always_comb begin
    lctl.load  = in_accept;
    lctl.first = first_r;
    lctl.prep  = (state_r == S_PREP);
    lctl.mac   = (state_r == S_MAC);
    lctl.last  = (mac_cnt_r == '0);
    lctl.upd   = (state_r == S_UPD);
    lctl.diff  = (state_r == S_DIFF);
    lctl.fix   = (state_r == S_FIX);
    gctl.start = (state_r == S_PREP) && !cur_first_r;
    gctl.first = in_accept && first_r;
  end

  // ---------------------------------------------------------------- datapath
  kts_gain u_gain (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (gctl),
    .noise_q (noise_q_r),
    .noise_r (noise_r_r),
    .gain    (gain),
    .done    (g_done)
  );

  kts_lane #(.ACC_WIDTH(ACC_WIDTH)) u_lane_x (
    .clk  (clk),
    .rst_n(rst_n),
    .ctl  (lctl),
    .step (in_tdata[27:0]),
    .gain (gain),
    .fix  (fix_x),
    .diff (diff_x)
  );

  kts_lane #(.ACC_WIDTH(ACC_WIDTH)) u_lane_y (
    .clk  (clk),
    .rst_n(rst_n),
    .ctl  (lctl),
    .step (in_tdata[55:28]),
    .gain (gain),
    .fix  (fix_y),
    .diff (diff_y)
  );

  // the angle difference feeds only the angle correction, never the warp test
  kts_lane #(.ACC_WIDTH(ACC_WIDTH)) u_lane_a (
    .clk  (clk),
    .rst_n(rst_n),
    .ctl  (lctl),
    .step (in_tdata[83:56]),
    .gain (gain),
    .fix  (fix_a),
    .diff (diff_a)
  );

  kts_merge u_merge (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (mrg_load),
    .fix_x     (fix_x),
    .fix_y     (fix_y),
    .fix_angle (fix_a),
    .diff_x    (diff_x),
    .diff_y    (diff_y),
    .limit_x   (limit_x_r),
    .limit_y   (limit_y_r),
    .ready     (mrg_ready),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

  // ---------------------------------------------------------------- checks
  a_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    g_done |-> (state_r == S_DIV))
    else $error("gain finished outside the divide wait");

  a_gain_max: assert property (@(posedge clk) disable iff (!rst_n)
    g_done |-> (gain <= kts_pkg::VAR_ONE))
    else $error("gain above 1.0");

  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    mrg_load |-> (!out_tvalid || out_tready))
    else $error("result loaded over a word not yet taken");

  a_one_frame: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept |=> !in_tready)
    else $error("second word taken while a frame is in work");

  a_angle_clamp: assert property (@(posedge clk) disable iff (!rst_n)
    mrg_load |-> (diff_a <= DIFF_MAX && diff_a >= -DIFF_MAX))
    else $error("angle difference outside its clamp");

endmodule
